### rtl/vertex_tangent_accumulator_defines.svh
// Assertion macros used by the tangent accumulator controller RTL.
// Depends on nothing; assumes clk and rst_n exist in the including module.
`ifndef VERTEX_TANGENT_ACCUMULATOR_DEFINES_SVH
`define VERTEX_TANGENT_ACCUMULATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define VTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vta assertion failed");
`define VTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vta assertion failed");
`else
`define VTA_ASSERT_IMP(lbl, ante, cons)
`define VTA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/vtacc_pkg.sv
// Types and fixed widths for the vertex tangent accumulator.
// No dependencies.
package vtacc_pkg;

    localparam int POS_W    = 16;
    localparam int IDX_W    = 12;
    localparam int DIF_W    = 17;
    localparam int PRD_W    = 34;
    localparam int RAW_W    = 35;
    localparam int MAG_W    = 24;
    localparam int L2_W     = 50;
    localparam int SQ_W     = 51;
    localparam int LEN_W    = 25;
    localparam int NUM_W    = 40;
    localparam int QUO_W    = 15;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 8;
    localparam int RES_W    = 16;
    localparam int REC_W    = 3 * SUM_W + CNT_W;
    localparam int FRAC_W   = 14;
    localparam int SQ_STEPS = 25;
    localparam int OP_W     = 5;

    localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH = 5'd1;
    localparam logic [OP_W-1:0] OP_CLR   = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL1  = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL2  = 5'd4;
    localparam logic [OP_W-1:0] OP_ABS   = 5'd5;
    localparam logic [OP_W-1:0] OP_SHR   = 5'd6;
    localparam logic [OP_W-1:0] OP_SHL   = 5'd7;
    localparam logic [OP_W-1:0] OP_TZERO = 5'd8;
    localparam logic [OP_W-1:0] OP_SQ    = 5'd9;
    localparam logic [OP_W-1:0] OP_SQI   = 5'd10;
    localparam logic [OP_W-1:0] OP_SQRT  = 5'd11;
    localparam logic [OP_W-1:0] OP_DIVN  = 5'd12;
    localparam logic [OP_W-1:0] OP_DIVA  = 5'd13;
    localparam logic [OP_W-1:0] OP_TAKE  = 5'd14;
    localparam logic [OP_W-1:0] OP_ARD   = 5'd15;
    localparam logic [OP_W-1:0] OP_AWR   = 5'd16;
    localparam logic [OP_W-1:0] OP_RRD   = 5'd17;
    localparam logic [OP_W-1:0] OP_RLAT  = 5'd18;
    localparam logic [OP_W-1:0] OP_OUT   = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      idx;
    } cmd_t;

    typedef struct packed {
        logic m_zero;
        logic norm_hi;
        logic norm_lo;
        logic div_done;
        logic clr_last;
        logic rd_zero;
    } sts_t;

endpackage

### rtl/vtacc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vtacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/vtacc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on vtacc_pkg.
module vtacc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vtacc_pkg::NUM_W-1:0]  num,
    input  logic [vtacc_pkg::LEN_W-1:0]  den,
    output logic [vtacc_pkg::QUO_W-1:0]  quo,
    output logic                         done
);
    localparam int NW = vtacc_pkg::NUM_W;
    localparam int QW = vtacc_pkg::QUO_W;

    logic [NW-1:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next, done_reg, done_next;
    logic          ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NW'(den) << (QW - 1);
            quo_next  = '0;
            cnt_next  = 4'(QW - 1);
            run_next  = 1'b1;
            done_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 4'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;
endmodule

### rtl/vtacc_dp.sv
// Datapath: corner latches, edge cross products, normalize, square root,
// sum store access and averaging. Depends on vtacc_pkg and vtacc_div.
module vtacc_dp #(
    parameter int VERTEX_SLOTS = 4096,
    parameter int AW = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vtacc_pkg::cmd_t               cmd,
    output vtacc_pkg::sts_t               sts,
    input  logic                          kind,
    input  logic [1:0]                    corner,
    input  logic [vtacc_pkg::IDX_W-1:0]   vertex_index,
    input  logic signed [15:0]            pos_x,
    input  logic signed [15:0]            pos_y,
    input  logic signed [15:0]            pos_z,
    input  logic signed [15:0]            tex_v,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [vtacc_pkg::REC_W-1:0]   ram_wdata,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [vtacc_pkg::REC_W-1:0]   ram_rdata,
    output logic                          done,
    output logic signed [15:0]            tan_x,
    output logic signed [15:0]            tan_y,
    output logic signed [15:0]            tan_z,
    output logic                          has_tangent,
    output logic [7:0]                    share_count
);
    localparam int DW = vtacc_pkg::DIF_W;
    localparam int RW = vtacc_pkg::RAW_W;
    localparam int SW = vtacc_pkg::SUM_W;
    localparam int CW = vtacc_pkg::CNT_W;
    localparam int QW = vtacc_pkg::SQ_W;
    localparam int LW = vtacc_pkg::LEN_W;
    localparam int NW = vtacc_pkg::NUM_W;
    localparam int REC_W_HI = vtacc_pkg::REC_W - 1;

    function automatic logic in_range(input logic [vtacc_pkg::IDX_W-1:0] v);
        in_range = 17'(v) < 17'(VERTEX_SLOTS);
    endfunction

    // corner latches
    logic signed [15:0] px_reg [3];
    logic signed [15:0] py_reg [3];
    logic signed [15:0] pz_reg [3];
    logic signed [15:0] tv_reg [3];
    logic [vtacc_pkg::IDX_W-1:0] cv_reg [3];
    logic [vtacc_pkg::IDX_W-1:0] rd_idx_reg;

    logic signed [vtacc_pkg::PRD_W-1:0] prod_reg;
    logic signed [RW-1:0] raw_reg [3];
    logic [RW-1:0] mag_reg [3];
    logic [RW-1:0] m_reg;
    logic neg_reg [3];
    logic [vtacc_pkg::L2_W-1:0] l2_reg;
    logic [QW-1:0] sn_reg, sr_reg, sb_reg;
    logic signed [15:0] res_reg [3];
    logic [SW-1:0] amag_reg [3];
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] clr_reg;
    logic done_reg;
    logic signed [15:0] otan_reg [3];
    logic ohas_reg;
    logic [7:0] ocnt_reg;

    logic [1:0] i;
    logic signed [DW-1:0] e1, e2, dv1, dv2;
    logic [RW-1:0] abs_w [3];
    logic [RW-1:0] max01;
    logic [QW-1:0] trial;
    logic [NW-1:0] div_num;
    logic [LW-1:0] div_den;
    logic [vtacc_pkg::QUO_W-1:0] div_q;
    logic div_done, div_start;
    logic [CW-1:0] rcnt;
    logic upd_ok;
    logic [vtacc_pkg::IDX_W-1:0] acc_v;

    assign i = cmd.idx;

    always_comb
    begin
        e1  = DW'(px_reg[1]) - DW'(px_reg[0]);
        e2  = DW'(px_reg[2]) - DW'(px_reg[0]);
        unique case (i)
            2'd1:
            begin
                e1 = DW'(py_reg[1]) - DW'(py_reg[0]);
                e2 = DW'(py_reg[2]) - DW'(py_reg[0]);
            end
            2'd2:
            begin
                e1 = DW'(pz_reg[1]) - DW'(pz_reg[0]);
                e2 = DW'(pz_reg[2]) - DW'(pz_reg[0]);
            end
            default:
            begin
                e1 = DW'(px_reg[1]) - DW'(px_reg[0]);
                e2 = DW'(px_reg[2]) - DW'(px_reg[0]);
            end
        endcase
        dv1 = DW'(tv_reg[1]) - DW'(tv_reg[0]);
        dv2 = DW'(tv_reg[2]) - DW'(tv_reg[0]);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            abs_w[k] = raw_reg[k][RW-1] ? RW'(-raw_reg[k]) : RW'(raw_reg[k]);
        end
        max01 = (abs_w[1] > abs_w[0]) ? abs_w[1] : abs_w[0];
    end

    assign trial = sr_reg + sb_reg;

    // divider operands: normalize or average
    always_comb
    begin
        if (cmd.op == vtacc_pkg::OP_DIVA)
        begin
            div_num = NW'(amag_reg[i]) + NW'(cnt_reg >> 1);
            div_den = LW'(cnt_reg);
        end
        else
        begin
            div_num = (NW'(mag_reg[i][vtacc_pkg::MAG_W-1:0]) << vtacc_pkg::FRAC_W)
                      + NW'(sr_reg[LW-1:1]);
            div_den = sr_reg[LW-1:0];
        end
    end
    assign div_start = (cmd.op == vtacc_pkg::OP_DIVN) || (cmd.op == vtacc_pkg::OP_DIVA);

    vtacc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .done  (div_done)
    );

    // store access
    assign acc_v  = cv_reg[i];
    assign upd_ok = in_range(acc_v) && (ram_rdata[REC_W_HI:3*SW] != {CW{1'b1}});

    always_comb
    begin
        ram_raddr = (cmd.op == vtacc_pkg::OP_RRD) ? AW'(rd_idx_reg) : AW'(acc_v);
        if (cmd.op == vtacc_pkg::OP_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (cmd.op == vtacc_pkg::OP_AWR) && upd_ok;
            ram_waddr = AW'(acc_v);
            ram_wdata = {ram_rdata[REC_W_HI:3*SW] + CW'(1),
                         ram_rdata[3*SW-1:2*SW] + SW'(res_reg[2]),
                         ram_rdata[2*SW-1:SW] + SW'(res_reg[1]),
                         ram_rdata[SW-1:0] + SW'(res_reg[0])};
        end
    end

    assign rcnt = in_range(rd_idx_reg) ? ram_rdata[REC_W_HI:3*SW] : '0;

    always_comb
    begin
        sts.m_zero   = (m_reg == '0);
        sts.norm_hi  = |m_reg[RW-1:vtacc_pkg::MAG_W];
        sts.norm_lo  = !(|m_reg[RW-1:vtacc_pkg::MAG_W-1]);
        sts.div_done = div_done;
        sts.clr_last = (clr_reg == AW'(VERTEX_SLOTS - 1));
        sts.rd_zero  = (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                px_reg[k] <= '0;
                py_reg[k] <= '0;
                pz_reg[k] <= '0;
                tv_reg[k] <= '0;
                cv_reg[k] <= '0;
            end
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == vtacc_pkg::OP_OUT);
            if (cmd.op == vtacc_pkg::OP_CLR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.op == vtacc_pkg::OP_LATCH && !kind && corner != 2'd3)
            begin
                px_reg[corner] <= pos_x;
                py_reg[corner] <= pos_y;
                pz_reg[corner] <= pos_z;
                tv_reg[corner] <= tex_v;
                cv_reg[corner] <= vertex_index;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            vtacc_pkg::OP_LATCH: rd_idx_reg <= vertex_index;
            vtacc_pkg::OP_MUL1:  prod_reg <= e1 * dv2;
            vtacc_pkg::OP_MUL2:  raw_reg[i] <= RW'(prod_reg) - RW'(e2 * dv1);
            vtacc_pkg::OP_ABS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= abs_w[k];
                    neg_reg[k] <= raw_reg[k][RW-1];
                end
                m_reg <= (abs_w[2] > max01) ? abs_w[2] : max01;
            end
            vtacc_pkg::OP_SHR:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= mag_reg[k] >> 1;
                end
                m_reg <= m_reg >> 1;
            end
            vtacc_pkg::OP_SHL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= mag_reg[k] << 1;
                end
                m_reg <= m_reg << 1;
            end
            vtacc_pkg::OP_TZERO:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    res_reg[k] <= '0;
                end
            end
            vtacc_pkg::OP_SQ:
            begin
                if (i == 2'd0)
                begin
                    l2_reg <= vtacc_pkg::L2_W'(mag_reg[0][vtacc_pkg::MAG_W-1:0]
                                               * mag_reg[0][vtacc_pkg::MAG_W-1:0]);
                end
                else
                begin
                    l2_reg <= l2_reg + vtacc_pkg::L2_W'(mag_reg[i][vtacc_pkg::MAG_W-1:0]
                                                        * mag_reg[i][vtacc_pkg::MAG_W-1:0]);
                end
            end
            vtacc_pkg::OP_SQI:
            begin
                sn_reg <= QW'(l2_reg);
                sr_reg <= '0;
                sb_reg <= QW'(1) << (2 * (vtacc_pkg::SQ_STEPS - 1));
            end
            vtacc_pkg::OP_SQRT:
            begin
                if (sn_reg >= trial)
                begin
                    sn_reg <= sn_reg - trial;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg <= sb_reg >> 2;
            end
            vtacc_pkg::OP_TAKE:
                res_reg[i] <= neg_reg[i] ? -16'(div_q) : 16'(div_q);
            vtacc_pkg::OP_RLAT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k]  <= ram_rdata[k*SW+SW-1];
                    amag_reg[k] <= ram_rdata[k*SW+SW-1] ? -ram_rdata[k*SW +: SW]
                                                        : ram_rdata[k*SW +: SW];
                end
                cnt_reg <= rcnt;
            end
            vtacc_pkg::OP_OUT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    otan_reg[k] <= (cnt_reg == '0) ? '0 : res_reg[k];
                end
                ohas_reg <= (cnt_reg != '0);
                ocnt_reg <= cnt_reg;
            end
            default: ;
        endcase
    end

    assign done        = done_reg;
    assign tan_x       = otan_reg[0];
    assign tan_y       = otan_reg[1];
    assign tan_z       = otan_reg[2];
    assign has_tangent = ohas_reg;
    assign share_count = ocnt_reg;
endmodule

### rtl/vtacc_ctrl.sv
// Controller state machine: sequences clear pass, triangle and read work.
// Depends on vtacc_pkg and the assertion macro header.
`include "vertex_tangent_accumulator_defines.svh"
module vtacc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            kind,
    input  logic [1:0]      corner,
    input  vtacc_pkg::sts_t sts,
    output vtacc_pkg::cmd_t cmd,
    output logic            busy
);
    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MUL1  = 5'd2;
    localparam logic [4:0] S_MUL2  = 5'd3;
    localparam logic [4:0] S_ABS   = 5'd4;
    localparam logic [4:0] S_NORM  = 5'd5;
    localparam logic [4:0] S_SQ    = 5'd6;
    localparam logic [4:0] S_SQI   = 5'd7;
    localparam logic [4:0] S_SQRT  = 5'd8;
    localparam logic [4:0] S_DIVS  = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_ARD   = 5'd11;
    localparam logic [4:0] S_AWR   = 5'd12;
    localparam logic [4:0] S_RRD   = 5'd13;
    localparam logic [4:0] S_RLAT  = 5'd14;
    localparam logic [4:0] S_RDIVS = 5'd15;
    localparam logic [4:0] S_RDIVW = 5'd16;
    localparam logic [4:0] S_ROUT  = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [4:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd.op     = vtacc_pkg::OP_NONE;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = vtacc_pkg::OP_CLR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op   = vtacc_pkg::OP_LATCH;
                    idx_next = 2'd0;
                    if (kind)
                    begin
                        state_next = S_RRD;
                    end
                    else if (corner == 2'd2)
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.op     = vtacc_pkg::OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op = vtacc_pkg::OP_MUL2;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = S_ABS;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_MUL1;
                end
            end
            S_ABS:
            begin
                cmd.op     = vtacc_pkg::OP_ABS;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                priority if (sts.m_zero)
                begin
                    cmd.op     = vtacc_pkg::OP_TZERO;
                    state_next = S_ARD;
                end
                else if (sts.norm_hi)
                begin
                    cmd.op = vtacc_pkg::OP_SHR;
                end
                else if (sts.norm_lo)
                begin
                    cmd.op = vtacc_pkg::OP_SHL;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op = vtacc_pkg::OP_SQ;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = S_SQI;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_SQI:
            begin
                cmd.op     = vtacc_pkg::OP_SQI;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op    = vtacc_pkg::OP_SQRT;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(vtacc_pkg::SQ_STEPS - 1))
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.op     = vtacc_pkg::OP_DIVN;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.op = vtacc_pkg::OP_TAKE;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = 2'd0;
                        state_next = S_ARD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_DIVS;
                    end
                end
            end
            S_ARD:
            begin
                cmd.op     = vtacc_pkg::OP_ARD;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.op = vtacc_pkg::OP_AWR;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_ARD;
                end
            end
            S_RRD:
            begin
                cmd.op     = vtacc_pkg::OP_RRD;
                state_next = S_RLAT;
            end
            S_RLAT:
            begin
                cmd.op     = vtacc_pkg::OP_RLAT;
                state_next = S_RDIVS;
            end
            S_RDIVS:
            begin
                if (sts.rd_zero)
                begin
                    state_next = S_ROUT;
                end
                else
                begin
                    cmd.op     = vtacc_pkg::OP_DIVA;
                    state_next = S_RDIVW;
                end
            end
            S_RDIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.op = vtacc_pkg::OP_TAKE;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = 2'd0;
                        state_next = S_ROUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_RDIVS;
                    end
                end
            end
            S_ROUT:
            begin
                cmd.op     = vtacc_pkg::OP_OUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `VTA_ASSERT_IMP(a_sqrt_bound, state_reg == S_SQRT, step_reg < 5'(vtacc_pkg::SQ_STEPS))
    `VTA_ASSERT_NXT(a_read_starts, state_reg == S_IDLE && start && kind, state_reg == S_RRD)
    `VTA_ASSERT_NXT(a_tri_starts, state_reg == S_IDLE && start && !kind && corner == 2'd2,
                    state_reg == S_MUL1 && idx_reg == 2'd0)
endmodule

### rtl/vertex_tangent_accumulator.sv
// Vertex tangent accumulator. Corner 0/1 requests are latched and busy stays low. Corner 2
// request: busy for 0..23 normalize shifts, 6 multiply steps, 25 root steps, three
// divides and three store read-modify-writes; a zero tangent skips shifts, root and divides.
// Read request: busy through three averaging divides, none for an untouched vertex; result
// strobes on done for one cycle right after, the receiver cannot stall it. After reset the
// store is cleared one slot per cycle with busy high. Depends on vtacc_pkg and submodules.
module vertex_tangent_accumulator #(
    parameter int VERTEX_SLOTS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [1:0]         corner,
    input  logic [11:0]        vertex_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic signed [15:0] tex_u,
    input  logic signed [15:0] tex_v,
    output logic               done,
    output logic signed [15:0] tan_x,
    output logic signed [15:0] tan_y,
    output logic signed [15:0] tan_z,
    output logic               has_tangent,
    output logic [7:0]         share_count
);
    // store address width; one word per vertex holds three sums and a count
    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

    vtacc_pkg::cmd_t cmd;
    vtacc_pkg::sts_t sts;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [vtacc_pkg::REC_W-1:0] ram_wdata, ram_rdata;
    logic                        u_unused;

    // the tangent only uses v deltas; u is accepted and dropped
    assign u_unused = ^tex_u;

    vtacc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .corner (corner),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    vtacc_dp #(
        .VERTEX_SLOTS (VERTEX_SLOTS),
        .AW           (AW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .corner       (corner),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_v        (tex_v),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .tan_x        (tan_x),
        .tan_y        (tan_y),
        .tan_z        (tan_z),
        .has_tangent  (has_tangent),
        .share_count  (share_count)
    );

    vtacc_ram #(
        .WIDTH (vtacc_pkg::REC_W),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
